FILE: rtl/jet_pkg.sv
`timescale 1ns / 1ps

package jet_pkg;

  // data formats
  localparam int FRAC_BITS = 28;
  localparam int ZW = 32;                      // z and c width, signed
  localparam int PW = 2 * ZW;                  // product width
  localparam int RW = PW - FRAC_BITS + 1;      // updated z before truncation
  localparam int AW = FRAC_BITS + 2;           // |z| once below the bound of 3
  localparam int SW = 2 * AW + 1;              // sum of squares

  localparam logic [RW-1:0] THREE = RW'(3) << FRAC_BITS;
  localparam logic [SW-1:0] NINE2 = SW'(9) << (2 * FRAC_BITS);

  localparam int ITER_BITS_DEF = 12;
  localparam int MAX_ITER_RST = 50;

  // configuration port
  localparam int CFG_W = 32;
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_C_REAL = 2'd0;
  localparam logic [CFG_AW-1:0] REG_C_IMAG = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_ITER = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic sq;
    logic chk;
    logic out_load;
  } jet_cmd_t;

  typedef struct packed {
    logic zero_lim;
    logic esc;
    logic ret;
    logic last;
  } jet_sts_t;

endpackage

FILE: rtl/jet_if.sv
`timescale 1ns / 1ps

interface jet_point_if;
  logic valid;
  logic ready;
  logic signed [jet_pkg::ZW-1:0] z_real;
  logic signed [jet_pkg::ZW-1:0] z_imag;

  modport source (output valid, z_real, z_imag, input ready);
  modport sink (input valid, z_real, z_imag, output ready);
endinterface

interface jet_result_if #(
  parameter int ITER_BITS = jet_pkg::ITER_BITS_DEF
);
  logic valid;
  logic ready;
  logic [ITER_BITS-1:0] iter_count;
  logic in_set;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, iter_count, in_set, red, green, blue, input ready);
  modport sink (input valid, iter_count, in_set, red, green, blue, output ready);
endinterface

FILE: rtl/jet_ctrl.sv
`timescale 1ns / 1ps

module jet_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  jet_pkg::jet_sts_t sts,
  output jet_pkg::jet_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       result_valid_next;
  logic       slot_free;

  assign slot_free = !result_valid || result_ready;
  assign point_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (point_valid) begin
          cmd.load = 1'b1;
          state_next = sts.zero_lim ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        state_next = (sts.esc || sts.ret || sts.last) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (result_valid && result_ready) begin
      result_valid_next = 1'b0;
    end
    if (cmd.out_load) begin
      result_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= result_valid_next;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");

  a_start: assert property (@(posedge clk) disable iff (rst)
    point_valid && point_ready |=> state == S_MUL || state == S_FIN)
    else $error("accepted point did not start");

  a_loop: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK && !(sts.esc || sts.ret || sts.last) |=> state == S_MUL)
    else $error("unfinished point left the loop");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && result_valid && !result_ready |=> state == S_FIN && result_valid)
    else $error("pending result overwritten");

endmodule

FILE: rtl/jet_dp.sv
`timescale 1ns / 1ps

module jet_dp #(
  parameter int ITER_BITS = jet_pkg::ITER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  jet_pkg::jet_cmd_t             cmd,
  output jet_pkg::jet_sts_t             sts,
  input  logic signed [jet_pkg::ZW-1:0] z_real,
  input  logic signed [jet_pkg::ZW-1:0] z_imag,
  input  logic signed [jet_pkg::ZW-1:0] c_real,
  input  logic signed [jet_pkg::ZW-1:0] c_imag,
  input  logic [ITER_BITS-1:0]          max_iter,
  output logic [ITER_BITS-1:0]          iter_count,
  output logic                          in_set,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue
);

  localparam int ZW = jet_pkg::ZW;
  localparam int PW = jet_pkg::PW;
  localparam int RW = jet_pkg::RW;
  localparam int AW = jet_pkg::AW;
  localparam int SW = jet_pkg::SW;

  logic signed [ZW-1:0] x, y, x0, y0;
  logic signed [PW-1:0] pxx, pyy, pxy;
  logic signed [PW-1:0] diff, re_sh, im_sh;
  logic signed [RW-1:0] re_next, im_next;
  logic signed [RW-1:0] re, im;
  logic [RW-1:0]        ar_full, ai_full;
  logic                 big_r, big_i;
  logic [AW-1:0]        ar, ai;
  logic [2*AW-1:0]      sq_r, sq_i;
  logic [SW-1:0]        mag2;
  logic [ITER_BITS-1:0] n;
  logic [ITER_BITS:0]   n_inc;
  logic                 res_set;
  logic [7:0]           n8;

  assign diff = pxx - pyy;
  assign re_sh = diff >>> jet_pkg::FRAC_BITS;
  assign im_sh = pxy >>> (jet_pkg::FRAC_BITS - 1);
  assign re_next = RW'(re_sh) + RW'(c_real);
  assign im_next = RW'(im_sh) + RW'(c_imag);
  assign ar_full = re_next[RW-1] ? RW'(-re_next) : RW'(re_next);
  assign ai_full = im_next[RW-1] ? RW'(-im_next) : RW'(im_next);

  assign mag2 = SW'(sq_r) + SW'(sq_i);
  assign n_inc = {1'b0, n} + 1'b1;

  assign sts.zero_lim = (max_iter == '0);
  assign sts.esc = big_r || big_i || (mag2 >= jet_pkg::NINE2);
  assign sts.ret = (re[ZW-1:0] == x0) && (im[ZW-1:0] == y0);
  assign sts.last = (n_inc == {1'b0, max_iter});

  assign n8 = 8'(n);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= z_real;
      y <= z_imag;
      x0 <= z_real;
      y0 <= z_imag;
      n <= '0;
      res_set <= sts.zero_lim;
    end
    if (cmd.mul) begin
      pxx <= x * x;
      pyy <= y * y;
      pxy <= x * y;
    end
    if (cmd.add) begin
      re <= re_next;
      im <= im_next;
      big_r <= (ar_full >= jet_pkg::THREE);
      big_i <= (ai_full >= jet_pkg::THREE);
      ar <= ar_full[AW-1:0];
      ai <= ai_full[AW-1:0];
    end
    if (cmd.sq) begin
      sq_r <= ar * ar;
      sq_i <= ai * ai;
    end
    if (cmd.chk) begin
      x <= re[ZW-1:0];
      y <= im[ZW-1:0];
      res_set <= !sts.esc && (sts.ret || sts.last);
      if (!sts.esc) begin
        n <= sts.ret ? max_iter : n_inc[ITER_BITS-1:0];
      end
    end
    if (cmd.out_load) begin
      iter_count <= n;
      in_set <= res_set;
      red <= res_set ? 8'd0 : n8 * 8'd10 + 8'd1;
      green <= res_set ? 8'd0 : {n8[6:0], 1'b0};
      blue <= res_set ? 8'd0 : {n8[6:0], 1'b0};
    end
  end

  a_return_count: assert property (@(posedge clk) disable iff (rst)
    cmd.chk && !sts.esc && sts.ret |=> n == $past(max_iter) && res_set)
    else $error("orbit return did not force the limit count");

  a_escape_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.chk && sts.esc |=> n == $past(n) && !res_set)
    else $error("escape changed the count");

endmodule

FILE: rtl/julia_escape_time.sv
`timescale 1ns / 1ps
// A point transaction runs k steps (1..max_iter) before its result is
// registered; a zero limit runs no steps. Each step passes through the
// multiply, reduce, square and compare states of the shared datapath.
// A new point is taken only once the last one has gone to the output
// register; the next point is taken while a result waits there.
// Reset (rst, synchronous): controller idle, no result, c = 0, max_iter = 50.

module julia_escape_time #(
  parameter int ITER_BITS = jet_pkg::ITER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  jet_point_if.sink                    point,
  jet_result_if.source                 result,
  input  logic                         cfg_wr,
  input  logic [jet_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [jet_pkg::CFG_W-1:0]    cfg_data
);

  logic signed [jet_pkg::ZW-1:0] c_real;
  logic signed [jet_pkg::ZW-1:0] c_imag;
  logic [ITER_BITS-1:0]          max_iter;
  jet_pkg::jet_cmd_t             cmd;
  jet_pkg::jet_sts_t             sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real <= '0;
      c_imag <= '0;
      max_iter <= ITER_BITS'(jet_pkg::MAX_ITER_RST);
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        jet_pkg::REG_C_REAL:   c_real <= cfg_data[jet_pkg::ZW-1:0];
        jet_pkg::REG_C_IMAG:   c_imag <= cfg_data[jet_pkg::ZW-1:0];
        jet_pkg::REG_MAX_ITER: max_iter <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  jet_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point.valid),
    .point_ready  (point.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  jet_dp #(
    .ITER_BITS (ITER_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .z_real     (point.z_real),
    .z_imag     (point.z_imag),
    .c_real     (c_real),
    .c_imag     (c_imag),
    .max_iter   (max_iter),
    .iter_count (result.iter_count),
    .in_set     (result.in_set),
    .red        (result.red),
    .green      (result.green),
    .blue       (result.blue)
  );

endmodule
